// ===== design/slpg_pkg.sv =====
package slpg_pkg;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_DISK = 2'd1;
  localparam logic [1:0] CMD_LINK = 2'd2;
  localparam logic [1:0] CMD_NOP  = 2'd3;

  localparam logic [1:0] MODE_NOINIT  = 2'd0;
  localparam logic [1:0] MODE_DOWN    = 2'd1;
  localparam logic [1:0] MODE_UP      = 2'd2;
  localparam logic [1:0] MODE_ERASING = 2'd3;

  localparam logic [23:0] COLOR_OFF       = 24'h000000;
  localparam logic [23:0] COLOR_BRIGHT    = 24'h008000;
  localparam logic [23:0] COLOR_DIM       = 24'h000200;
  localparam logic [23:0] COLOR_IDLE      = 24'h001000;
  localparam logic [23:0] COLOR_NOINIT    = 24'h002000;
  localparam logic [23:0] COLOR_LINK_ACT  = 24'h800000;
  localparam logic [23:0] COLOR_LINK_IDLE = 24'h100000;

  localparam logic [2:0] PULSE_TICKS = 3'd5;

endpackage

// ===== design/status_led_pattern_generator.sv =====
// Throughput: one input beat per cycle, unless a tick beat in the input
// register waits on a stalled output; status beats produce no output beat.
// An input register feeds short logic into an output register; both stall
// together only when a color beat waits and out_tready is low.
// Reset: synchronous, active low on rst_n; clears both modes, pending flags,
// tick counters and all valid flags.
module status_led_pattern_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [1:0] status, [2] xchange, [7:3] zero
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [23:0] grb_color
);

  logic       s1_valid_r;
  logic [1:0] s1_cmd_r;
  logic [1:0] s1_status_r;
  logic       s1_xchange_r;

  logic [1:0] disk_mode_r, disk_mode_nxt;
  logic [1:0] link_mode_r, link_mode_nxt;
  logic       disk_pend_r, disk_pend_nxt;
  logic       link_pend_r, link_pend_nxt;
  logic [4:0] disk_ticks_r, disk_ticks_nxt;
  logic [2:0] link_ticks_r, link_ticks_nxt;

  logic        out_valid_r;
  logic [23:0] out_color_r;

  logic        is_tick;
  logic        out_load;
  logic        s1_adv;
  logic [5:0]  disk_inc;
  logic [4:0]  disk_cnt;
  logic [2:0]  link_cnt;
  logic [23:0] color;

  assign is_tick   = (s1_cmd_r == slpg_pkg::CMD_TICK);
  assign out_load  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!is_tick || out_load);
  assign in_tready = !s1_valid_r || s1_adv;
  assign disk_inc  = {1'b0, disk_ticks_r} + 6'd1;

  always_comb begin
    disk_mode_nxt  = disk_mode_r;
    link_mode_nxt  = link_mode_r;
    disk_pend_nxt  = disk_pend_r;
    link_pend_nxt  = link_pend_r;
    disk_ticks_nxt = disk_ticks_r;
    link_ticks_nxt = link_ticks_r;
    disk_cnt       = disk_ticks_r;
    link_cnt       = link_ticks_r;
    color          = slpg_pkg::COLOR_OFF;

    unique case (disk_mode_r)
      slpg_pkg::MODE_ERASING: begin
        if (disk_inc >= 6'd30) begin
          disk_cnt = 5'(disk_inc - 6'd30);
        end else if (disk_inc >= 6'd20) begin
          disk_cnt = 5'(disk_inc - 6'd20);
        end else if (disk_inc >= 6'd10) begin
          disk_cnt = 5'(disk_inc - 6'd10);
        end else begin
          disk_cnt = disk_inc[4:0];
        end
        color = (disk_cnt < 5'd5) ? slpg_pkg::COLOR_BRIGHT : slpg_pkg::COLOR_OFF;
      end
      slpg_pkg::MODE_DOWN: begin
        color = slpg_pkg::COLOR_DIM;
      end
      slpg_pkg::MODE_UP: begin
        if (disk_pend_r) begin
          disk_cnt = {2'b00, slpg_pkg::PULSE_TICKS};
        end
        if (disk_cnt != 5'd0) begin
          disk_cnt = disk_cnt - 5'd1;
          color    = slpg_pkg::COLOR_BRIGHT;
        end else begin
          color = slpg_pkg::COLOR_IDLE;
        end
      end
      slpg_pkg::MODE_NOINIT: begin
        disk_cnt = (disk_inc >= 6'd20) ? 5'(disk_inc - 6'd20) : disk_inc[4:0];
        color = (disk_cnt < 5'd3) ? slpg_pkg::COLOR_NOINIT : slpg_pkg::COLOR_DIM;
      end
    endcase

    if (link_mode_r == slpg_pkg::MODE_UP) begin
      if (link_pend_r) begin
        link_cnt = slpg_pkg::PULSE_TICKS;
      end
      if (link_cnt != 3'd0) begin
        link_cnt = link_cnt - 3'd1;
        color    = color | slpg_pkg::COLOR_LINK_ACT;
      end else begin
        color = color | slpg_pkg::COLOR_LINK_IDLE;
      end
    end

    if (s1_adv) begin
      unique case (s1_cmd_r)
        slpg_pkg::CMD_TICK: begin
          disk_ticks_nxt = disk_cnt;
          if (disk_mode_r == slpg_pkg::MODE_UP) begin
            disk_pend_nxt = 1'b0;
          end
          if (link_mode_r == slpg_pkg::MODE_UP) begin
            link_ticks_nxt = link_cnt;
            link_pend_nxt  = 1'b0;
          end
        end
        slpg_pkg::CMD_DISK: begin
          disk_mode_nxt = s1_status_r;
          disk_pend_nxt = s1_xchange_r;
        end
        slpg_pkg::CMD_LINK: begin
          link_mode_nxt = s1_status_r;
          link_pend_nxt = s1_xchange_r;
        end
        slpg_pkg::CMD_NOP: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      disk_mode_r  <= slpg_pkg::MODE_NOINIT;
      link_mode_r  <= slpg_pkg::MODE_NOINIT;
      disk_pend_r  <= 1'b0;
      link_pend_r  <= 1'b0;
      disk_ticks_r <= 5'd0;
      link_ticks_r <= 3'd0;
    end else begin
      disk_mode_r  <= disk_mode_nxt;
      link_mode_r  <= link_mode_nxt;
      disk_pend_r  <= disk_pend_nxt;
      link_pend_r  <= link_pend_nxt;
      disk_ticks_r <= disk_ticks_nxt;
      link_ticks_r <= link_ticks_nxt;
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_load) begin
        out_valid_r <= s1_adv && is_tick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r     <= in_tuser;
      s1_status_r  <= in_tdata[1:0];
      s1_xchange_r <= in_tdata[2];
    end
    if (out_load && s1_adv && is_tick) begin
      out_color_r <= color;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_color_r;

endmodule

// ===== design/slpg_checker.sv =====
module slpg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // hold a stalled beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output beat changed");

  // disk part of the color is one of the base colors
  a_disk_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:0] == slpg_pkg::COLOR_OFF[15:0]) ||
                   (out_tdata[15:0] == slpg_pkg::COLOR_BRIGHT[15:0]) ||
                   (out_tdata[15:0] == slpg_pkg::COLOR_DIM[15:0]) ||
                   (out_tdata[15:0] == slpg_pkg::COLOR_IDLE[15:0]) ||
                   (out_tdata[15:0] == slpg_pkg::COLOR_NOINIT[15:0]))
    else $error("unexpected disk color");

  // link part is off, pulse or steady
  a_link_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[23:16] == 8'h00) ||
                   (out_tdata[23:16] == slpg_pkg::COLOR_LINK_ACT[23:16]) ||
                   (out_tdata[23:16] == slpg_pkg::COLOR_LINK_IDLE[23:16]))
    else $error("unexpected link color");

  // drop output valid after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind status_led_pattern_generator slpg_checker u_slpg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
